/* hw/rtl/lsmf_pkg.sv */
// Shared types and constants for the line segment match filter.
`default_nettype none

package lsmf_pkg;

    // Item kinds carried on the input tuser
    typedef logic [1:0] t_action;
    localparam t_action ACT_CLEAR = 2'd0;
    localparam t_action ACT_ADD   = 2'd1;
    localparam t_action ACT_TEST  = 2'd2;

    localparam int LIMIT_W = 27;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 27'd500;

    localparam int TOTAL_W = 32;

    // Last value of the drain counter; the drain state spans the distance unit pipeline
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_SUM,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

/* hw/rtl/line_segment_match_filter_top.sv */
// Top level of the line segment match filter: control sequencer, reference chain, result register.
`default_nettype none

// Each item is a clear, an add or a test, selected by the input tuser. References sit in a
// chain of MAX_SEGMENTS cells; a test rotates the whole chain once through a single shared
// three-stage distance unit. A test passes through the length, sum, scan, drain and done states,
// a clear or add through length, sum and done. The result sits in an output register, so the
// next item is accepted in the cycle after the result is loaded, even if it has not been taken.
// match_limit may be rewritten only while no item is in flight.
module line_segment_match_filter_top #(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_BITS   = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    // start_x, start_y, end_x, end_y
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] i_s_tdata,
    // action
    input  wire logic [1:0]                   i_s_tuser,
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    // unmatched, rejected, length_sq, unmatched_total, stored_count
    output logic [((2+2*COORD_BITS+1+32+$clog2(MAX_SEGMENTS+1)+7)/8)*8-1:0] o_m_tdata,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [lsmf_pkg::LIMIT_W-1:0] i_cfg_data
);
    import lsmf_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int SEG_W  = 4*CB;
    localparam int LEN_W  = 2*CB + 1;
    localparam int CNTW   = $clog2(MAX_SEGMENTS+1);
    localparam int IDXW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int OUT_W  = 2 + LEN_W + TOTAL_W + CNTW;
    localparam int OUT_TW = ((OUT_W+7)/8)*8;

    function automatic logic [CB-1:0] f_absdiff(input logic [CB-1:0] a, input logic [CB-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    t_state              r_state;
    t_state              n_state;
    logic [SEG_W-1:0]    r_item;
    t_action             r_act;
    logic [CB-1:0]       r_ldx;
    logic [CB-1:0]       r_ldy;
    logic [LEN_W-1:0]    r_len;
    logic [IDXW-1:0]     r_idx;
    logic [1:0]          r_drain;
    logic                r_match;
    logic [CNTW-1:0]     r_count;
    logic [CNTW-1:0]     n_count;
    logic [TOTAL_W-1:0]  r_total;
    logic [TOTAL_W-1:0]  n_total;
    logic [LIMIT_W-1:0]  r_limit;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    logic                w_s_ready;
    logic                w_scan;
    logic                w_finish;
    logic                w_write;
    logic                w_out_free;
    logic                w_chain_en;
    logic [SEG_W-1:0]    w_chain_in;
    logic [SEG_W-1:0]    w_q [MAX_SEGMENTS];
    logic                w_issue;
    logic                w_hit;
    logic [2*CB-1:0]     w_sqx;
    logic [2*CB-1:0]     w_sqy;
    logic [LEN_W-1:0]    w_len;
    logic [TOTAL_W:0]    w_sum;
    logic                w_unm;
    logic                w_rej;
    logic [LEN_W-1:0]    w_res_len;
    logic                w_room;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_room     = r_count < CNTW'(MAX_SEGMENTS);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_s_tvalid) n_state = ST_LEN;
            ST_LEN:   n_state = ST_SUM;
            ST_SUM:   n_state = (r_act == ACT_TEST) ? ST_SCAN : ST_DONE;
            ST_SCAN:  if (r_idx == '0) n_state = ST_DRAIN;
            ST_DRAIN: if (r_drain == DRAIN_LAST) n_state = ST_DONE;
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_s_ready = (r_state == ST_IDLE);
        w_scan    = (r_state == ST_SCAN);
        w_finish  = (r_state == ST_DONE) && w_out_free;
        w_write   = w_finish && (r_act == ACT_ADD) && w_room;
    end

    // result of the item in flight
    assign w_sum = {1'b0, r_total} + (TOTAL_W+1)'(r_len);

    always_comb begin
        w_unm     = 1'b0;
        w_rej     = 1'b0;
        w_res_len = r_len;
        n_count   = r_count;
        n_total   = r_total;
        unique case (r_act)
            ACT_CLEAR: begin
                w_res_len = '0;
                n_count   = '0;
                n_total   = '0;
            end
            ACT_ADD: begin
                if (w_room) begin
                    n_count = r_count + 1'b1;
                end else begin
                    w_rej = 1'b1;
                end
            end
            ACT_TEST: begin
                if (!r_match) begin
                    w_unm   = 1'b1;
                    n_total = w_sum[TOTAL_W] ? '1 : w_sum[TOTAL_W-1:0];
                end
            end
            default: begin
                w_res_len = '0;
            end
        endcase
    end

    // chain rotates during a scan, shifts the new reference in on an add when there is room
    assign w_chain_en = w_scan || w_write;
    assign w_chain_in = w_scan ? w_q[MAX_SEGMENTS-1] : r_item;

    for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_chain
        if (g == 0) begin : g_head
            lsmf_cell #(.SEG_W(SEG_W)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_chain_en),
                .i_d   (w_chain_in),
                .o_q   (w_q[g])
            );
        end else begin : g_body
            lsmf_cell #(.SEG_W(SEG_W)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_chain_en),
                .i_d   (w_q[g-1]),
                .o_q   (w_q[g])
            );
        end
    end

    // last cell holds entry r_idx; only entries below the count are live
    assign w_issue = w_scan && (CNTW'(r_idx) < r_count);

    lsmf_dist #(.COORD_BITS(CB)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_issue),
        .i_seg   (r_item),
        .i_ref   (w_q[MAX_SEGMENTS-1]),
        .i_limit (r_limit),
        .o_hit   (w_hit)
    );

    assign w_sqx = r_ldx * r_ldx;
    assign w_sqy = r_ldy * r_ldy;
    assign w_len = LEN_W'(w_sqx) + LEN_W'(w_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
            r_match     <= 1'b0;
            r_drain     <= '0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (w_finish) begin
                r_count <= n_count;
                r_total <= n_total;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_s_ready && i_s_tvalid) begin
                r_match <= 1'b0;
            end else if (r_state == ST_SCAN || r_state == ST_DRAIN) begin
                r_match <= r_match | w_hit;
            end
            if (r_state == ST_SUM) begin
                r_idx <= IDXW'(MAX_SEGMENTS-1);
            end else if (w_scan) begin
                r_idx <= r_idx - 1'b1;
            end
            if (r_state == ST_DRAIN) begin
                r_drain <= r_drain + 1'b1;
            end else begin
                r_drain <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_ready && i_s_tvalid) begin
            r_item <= i_s_tdata[SEG_W-1:0];
            r_act  <= i_s_tuser;
        end
        if (r_state == ST_LEN) begin
            r_ldx <= f_absdiff(r_item[2*CB +: CB], r_item[0 +: CB]);
            r_ldy <= f_absdiff(r_item[3*CB +: CB], r_item[CB +: CB]);
        end
        if (r_state == ST_SUM) begin
            r_len <= w_len;
        end
        if (w_finish) begin
            r_out_data <= {n_count, n_total, w_res_len, w_rej, w_unm};
        end
    end

    assign o_s_tready  = w_s_ready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = OUT_TW'(r_out_data);
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

/* hw/rtl/lsmf_cell.sv */
// One storage cell of the reference chain: holds a segment, takes its neighbor's on shift.
`default_nettype none

module lsmf_cell #(
    parameter int SEG_W = 48
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [SEG_W-1:0] i_d,
    output logic      [SEG_W-1:0] o_q
);

    logic [SEG_W-1:0] r_seg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_seg <= i_d;
        end
    end

    assign o_q = r_seg;

endmodule

`default_nettype wire

/* hw/rtl/lsmf_dist.sv */
// Shared three-stage distance unit: both endpoint pairings against one reference.
`default_nettype none

module lsmf_dist #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic [4*COORD_BITS-1:0]        i_seg,
    input  wire logic [4*COORD_BITS-1:0]        i_ref,
    input  wire logic [lsmf_pkg::LIMIT_W-1:0]   i_limit,
    output logic                                o_hit
);
    import lsmf_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int SW = 2*CB + 2;
    localparam int CW = (SW > LIMIT_W) ? SW : LIMIT_W;

    function automatic logic [CB-1:0] f_absdiff(input logic [CB-1:0] a, input logic [CB-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // coordinate order in each vector: sx, sy, ex, ey from the low bits up
    logic [CB-1:0]   w_s [4];
    logic [CB-1:0]   w_r [4];
    logic [CB-1:0]   w_d [8];
    logic [CB-1:0]   r_d [8];
    logic [2*CB-1:0] r_sq [8];
    logic [SW-1:0]   w_fwd;
    logic [SW-1:0]   w_rev;
    logic            r_v1;
    logic            r_v2;
    logic            r_hit;

    for (genvar g = 0; g < 4; g++) begin : g_unpack
        assign w_s[g] = i_seg[g*CB +: CB];
        assign w_r[g] = i_ref[g*CB +: CB];
    end

    always_comb begin
        // forward: start-start, end-end
        w_d[0] = f_absdiff(w_s[0], w_r[0]);
        w_d[1] = f_absdiff(w_s[1], w_r[1]);
        w_d[2] = f_absdiff(w_s[2], w_r[2]);
        w_d[3] = f_absdiff(w_s[3], w_r[3]);
        // reversed: start-end, end-start
        w_d[4] = f_absdiff(w_s[0], w_r[2]);
        w_d[5] = f_absdiff(w_s[1], w_r[3]);
        w_d[6] = f_absdiff(w_s[2], w_r[0]);
        w_d[7] = f_absdiff(w_s[3], w_r[1]);
    end

    assign w_fwd = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]) + SW'(r_sq[3]);
    assign w_rev = SW'(r_sq[4]) + SW'(r_sq[5]) + SW'(r_sq[6]) + SW'(r_sq[7]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_v1  <= i_valid;
            r_v2  <= r_v1;
            r_hit <= r_v2 && ((CW'(w_fwd) < CW'(i_limit)) || (CW'(w_rev) < CW'(i_limit)));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 8; k++) begin
            r_d[k]  <= w_d[k];
            r_sq[k] <= r_d[k] * r_d[k];
        end
    end

    assign o_hit = r_hit;

endmodule

`default_nettype wire

/* hw/rtl/lsmf_checker.sv */
// Port-level checker for the line segment match filter, bound to the top level.
`default_nettype none

module lsmf_checker #(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_BITS   = 12
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic o_m_tvalid,
    input  wire logic i_m_tready,
    input  wire logic [((2+2*COORD_BITS+1+32+$clog2(MAX_SEGMENTS+1)+7)/8)*8-1:0] o_m_tdata
);
    import lsmf_pkg::*;

    localparam int LEN_W = 2*COORD_BITS + 1;
    localparam int CNTW  = $clog2(MAX_SEGMENTS+1);
    localparam int LEN_L = 2;
    localparam int TOT_L = LEN_L + LEN_W;
    localparam int CNT_L = TOT_L + TOTAL_W;

    logic                c_unm;
    logic                c_rej;
    logic [LEN_W-1:0]    c_len;
    logic [TOTAL_W-1:0]  c_total;
    logic [CNTW-1:0]     c_count;

    assign c_unm   = o_m_tdata[0];
    assign c_rej   = o_m_tdata[1];
    assign c_len   = o_m_tdata[LEN_L +: LEN_W];
    assign c_total = o_m_tdata[TOT_L +: TOTAL_W];
    assign c_count = o_m_tdata[CNT_L +: CNTW];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result item changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> c_count <= CNTW'(MAX_SEGMENTS))
        else $error("stored count beyond table size");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(c_unm && c_rej))
        else $error("unmatched and rejected both set");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && c_rej |-> c_count == CNTW'(MAX_SEGMENTS))
        else $error("add rejected with room left");

    a_total_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && c_unm |-> TOTAL_W'(c_len) <= c_total)
        else $error("total below length of unmatched item");

endmodule

bind line_segment_match_filter_top lsmf_checker #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
) u_lsmf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
